// ===== hdl/ypc_pkg.sv =====
// Shared types, constants and helper functions of the yaw/pitch camera orientation block.
`default_nettype none

package ypc_pkg;

  // Design constants
  localparam int ROTATION_STEPS   = 16;
  localparam int VECTOR_FRAC_BITS = 14;

  localparam int OUT_W       = 16;
  localparam int DELTA_W     = 16;
  localparam int SENS_W      = 16;
  localparam int LIMIT_W     = 23;
  localparam int YAW_W       = 25;
  localparam int PITCH_W     = 24;
  localparam int STEP_W      = 25;
  localparam int ANGLE_W     = 26;
  localparam int CORDIC_W    = 34;
  localparam int MUL_W       = 32;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 23;
  localparam int TABLE_LEN   = 24;
  localparam int TABLE_IDX_W = $clog2(TABLE_LEN);
  localparam int STEP_CNT_W  = $clog2(ROTATION_STEPS);

  localparam int DROP_ONE = 30 - VECTOR_FRAC_BITS;
  localparam int DROP_TWO = 60 - VECTOR_FRAC_BITS;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_LIMIT = 2'd1;

  localparam logic [SENS_W-1:0]  SENS_RESET  = 16'd3277;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 23'd5832704;

  // Angles are held in 1/65536 degree
  localparam logic signed [ANGLE_W-1:0] ANG_FULL    = 26'sd23592960;
  localparam logic signed [ANGLE_W-1:0] ANG_HALF    = 26'sd11796480;
  localparam logic signed [ANGLE_W-1:0] ANG_QUARTER = 26'sd5898240;

  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic signed [ANGLE_W-1:0] ARC_TABLE [TABLE_LEN] = '{
    26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
    26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
    26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
    26'sd917,     26'sd458,     26'sd229,    26'sd115,
    26'sd57,      26'sd29,      26'sd14,     26'sd7,
    26'sd4,       26'sd2,       26'sd1,      26'sd0
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_MUL_Y,
    ST_UPDATE,
    ST_LOAD_YAW,
    ST_RUN_YAW,
    ST_LOAD_PITCH,
    ST_RUN_PITCH,
    ST_PROD,
    ST_EMIT
  } seq_state_e;

  typedef struct packed {
    logic                      start;
    logic signed [ANGLE_W-1:0] angle;
  } cordic_ctrl_t;

  typedef struct packed {
    logic                       done;
    logic signed [CORDIC_W-1:0] sin_v;
    logic signed [CORDIC_W-1:0] cos_v;
  } cordic_res_t;

  // Angle step: product scaled down by 256, nearest with ties upwards.
  function automatic logic signed [STEP_W-1:0] round_step(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = (p + 64'sd128) >>> 8;
    return t[STEP_W-1:0];
  endfunction

  // Round away the given fraction bits, saturate to plus or minus one, keep 16 bits.
  function automatic logic [OUT_W-1:0] emit_q(input logic signed [PROD_W-1:0] v,
                                              input int drop);
    logic signed [PROD_W-1:0] r;
    logic signed [PROD_W-1:0] one;
    one = 64'sd1 <<< VECTOR_FRAC_BITS;
    r   = v;
    if (drop > 0) begin
      r = (v + (64'sd1 <<< (drop - 1))) >>> drop;
    end
    if (r > one) begin
      r = one;
    end
    if (r < -one) begin
      r = -one;
    end
    return r[OUT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ypc_angle.sv =====
// Stored yaw and pitch angles with yaw wrap-around and pitch clamp.
`default_nettype none

module ypc_angle (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              upd_i,
  input  wire logic signed [ypc_pkg::STEP_W-1:0] step_x_i,
  input  wire logic signed [ypc_pkg::STEP_W-1:0] step_y_i,
  input  wire logic [ypc_pkg::LIMIT_W-1:0]       pitch_limit_i,
  output logic [ypc_pkg::YAW_W-1:0]              yaw_o,
  output logic signed [ypc_pkg::PITCH_W-1:0]     pitch_o
);

  logic [ypc_pkg::YAW_W-1:0]                yaw_q, yaw_d;
  logic signed [ypc_pkg::PITCH_W-1:0]       pitch_q, pitch_d;
  logic signed [ypc_pkg::YAW_W+1:0]         yaw_sum;
  logic signed [ypc_pkg::YAW_W+1:0]         full_turn;
  logic signed [ypc_pkg::ANGLE_W-1:0]       pitch_sum;
  logic signed [ypc_pkg::ANGLE_W-1:0]       lim_s;
  logic [ypc_pkg::LIMIT_W-1:0]              lim;

  assign full_turn = (ypc_pkg::YAW_W + 2)'(ypc_pkg::ANG_FULL);
  assign yaw_sum   = $signed({2'b00, yaw_q}) + (ypc_pkg::YAW_W + 2)'(step_x_i);
  assign pitch_sum = ypc_pkg::ANGLE_W'(pitch_q) + ypc_pkg::ANGLE_W'(step_y_i);

  // A limit beyond a quarter turn is held at a quarter turn.
  assign lim   = ($signed({3'b000, pitch_limit_i}) > ypc_pkg::ANG_QUARTER) ?
                 ypc_pkg::LIMIT_W'(ypc_pkg::ANG_QUARTER) : pitch_limit_i;
  assign lim_s = $signed({3'b000, lim});

  always_comb begin
    yaw_d   = yaw_q;
    pitch_d = pitch_q;
    if (upd_i) begin
      // One step is always smaller than a full turn, so one correction suffices.
      if (yaw_sum < 0) begin
        yaw_d = ypc_pkg::YAW_W'(yaw_sum + full_turn);
      end else if (yaw_sum >= full_turn) begin
        yaw_d = ypc_pkg::YAW_W'(yaw_sum - full_turn);
      end else begin
        yaw_d = ypc_pkg::YAW_W'(yaw_sum);
      end
      if (pitch_sum > lim_s) begin
        pitch_d = ypc_pkg::PITCH_W'(lim_s);
      end else if (pitch_sum < -lim_s) begin
        pitch_d = ypc_pkg::PITCH_W'(-lim_s);
      end else begin
        pitch_d = ypc_pkg::PITCH_W'(pitch_sum);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yaw_q   <= '0;
      pitch_q <= '0;
    end else begin
      yaw_q   <= yaw_d;
      pitch_q <= pitch_d;
    end
  end

  assign yaw_o   = yaw_q;
  assign pitch_o = pitch_q;

endmodule

`default_nettype wire

// ===== hdl/ypc_cordic.sv =====
// Rotation-mode CORDIC giving sine and cosine, one micro-rotation per cycle.
`default_nettype none

module ypc_cordic (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire ypc_pkg::cordic_ctrl_t ctrl_i,
  output ypc_pkg::cordic_res_t       res_o
);

  localparam logic [ypc_pkg::STEP_CNT_W-1:0] LastStep =
    ypc_pkg::STEP_CNT_W'(ypc_pkg::ROTATION_STEPS - 1);

  logic signed [ypc_pkg::CORDIC_W-1:0] x_q, x_d, y_q, y_d, x_sh, y_sh;
  logic signed [ypc_pkg::ANGLE_W-1:0]  a_q, a_d, a_wrap, a_fold, arc;
  logic                                flip_q, flip_d, fold_flip;
  logic [ypc_pkg::STEP_CNT_W-1:0]      cnt_q, cnt_d;
  logic                                busy_q, busy_d, done_q, done_d;

  // Bring the angle into half a turn either side, then into the right half plane.
  always_comb begin
    if (ctrl_i.angle > ypc_pkg::ANG_HALF) begin
      a_wrap = ctrl_i.angle - ypc_pkg::ANG_FULL;
    end else if (ctrl_i.angle <= -ypc_pkg::ANG_HALF) begin
      a_wrap = ctrl_i.angle + ypc_pkg::ANG_FULL;
    end else begin
      a_wrap = ctrl_i.angle;
    end
    fold_flip = 1'b0;
    a_fold    = a_wrap;
    if (a_wrap > ypc_pkg::ANG_QUARTER) begin
      a_fold    = a_wrap - ypc_pkg::ANG_HALF;
      fold_flip = 1'b1;
    end else if (a_wrap < -ypc_pkg::ANG_QUARTER) begin
      a_fold    = a_wrap + ypc_pkg::ANG_HALF;
      fold_flip = 1'b1;
    end
  end

  assign x_sh = x_q >>> cnt_q;
  assign y_sh = y_q >>> cnt_q;
  assign arc  = ypc_pkg::ARC_TABLE[ypc_pkg::TABLE_IDX_W'(cnt_q)];

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    a_d    = a_q;
    flip_d = flip_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctrl_i.start) begin
      x_d    = ypc_pkg::CORDIC_GAIN;
      y_d    = '0;
      a_d    = a_fold;
      flip_d = fold_flip;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!a_q[ypc_pkg::ANGLE_W-1]) begin
        x_d = x_q - y_sh;
        y_d = y_q + x_sh;
        a_d = a_q - arc;
      end else begin
        x_d = x_q + y_sh;
        y_d = y_q - x_sh;
        a_d = a_q + arc;
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    a_q    <= a_d;
    flip_q <= flip_d;
  end

  assign res_o.done  = done_q;
  assign res_o.sin_v = flip_q ? -y_q : y_q;
  assign res_o.cos_v = flip_q ? -x_q : x_q;

endmodule

`default_nettype wire

// ===== hdl/yaw_pitch_camera_orientation.sv =====
// Top level: sequencer, shared multiplier and output register of the camera orientation block.
//
//   channel   direction  handshake                  payload
//   in        input      in_valid_i / in_ready_o    mouse_dx_i, mouse_dy_i
//   out       output     out_valid_o / out_ready_i  forward_*, side_*, upward_*
//   cfg       input      cfg_we_i                   cfg_index_i, cfg_data_i
//
// An item passes through two step products on the shared multiplier, one angle update,
// two CORDIC runs, the vector products through the same multiplier and one load of the
// output register.
// in_ready_o is high only while the sequencer is idle. The output register holds a finished
// word while the next item is worked on; the sequencer waits only if that word is still untaken.
// Reset returns the angles to zero and the registers to their defaults.
`default_nettype none

module yaw_pitch_camera_orientation (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [ypc_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  wire logic [ypc_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic signed [ypc_pkg::DELTA_W-1:0]    mouse_dx_i,
  input  wire logic signed [ypc_pkg::DELTA_W-1:0]    mouse_dy_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic signed [ypc_pkg::OUT_W-1:0]           forward_x_o,
  output logic signed [ypc_pkg::OUT_W-1:0]           forward_y_o,
  output logic signed [ypc_pkg::OUT_W-1:0]           forward_z_o,
  output logic signed [ypc_pkg::OUT_W-1:0]           side_x_o,
  output logic signed [ypc_pkg::OUT_W-1:0]           side_z_o,
  output logic signed [ypc_pkg::OUT_W-1:0]           upward_x_o,
  output logic signed [ypc_pkg::OUT_W-1:0]           upward_y_o,
  output logic signed [ypc_pkg::OUT_W-1:0]           upward_z_o
);

  localparam int PcntW = 3;
  localparam logic [PcntW-1:0] PcntLast = 3'd4;

  ypc_pkg::seq_state_e state_q, state_d;

  logic [ypc_pkg::SENS_W-1:0]           sens_q;
  logic [ypc_pkg::LIMIT_W-1:0]          limit_q;
  logic signed [ypc_pkg::DELTA_W-1:0]   dx_q, dy_q;
  logic signed [ypc_pkg::MUL_W-1:0]     mul_a, mul_b;
  logic signed [ypc_pkg::PROD_W-1:0]    prod_q;
  logic signed [ypc_pkg::STEP_W-1:0]    step_x_q, step_y;
  logic signed [ypc_pkg::CORDIC_W-1:0]  sy_q, cy_q;
  logic [PcntW-1:0]                     pcnt_q;
  logic [ypc_pkg::OUT_W-1:0]            fx_q, fz_q, ux_q, uz_q, emit_v;
  logic                                 out_valid_q, can_load;
  logic [ypc_pkg::YAW_W-1:0]            yaw;
  logic signed [ypc_pkg::PITCH_W-1:0]   pitch;

  // Sequencer controls
  logic accept, angle_upd, cap_yaw, load_out, in_ready;
  ypc_pkg::cordic_ctrl_t cordic_ctrl;
  ypc_pkg::cordic_res_t  cordic_res;

  assign can_load = !out_valid_q || out_ready_i;
  assign accept   = in_valid_i && in_ready;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ypc_pkg::ST_IDLE:       if (in_valid_i) state_d = ypc_pkg::ST_MUL_X;
      ypc_pkg::ST_MUL_X:      state_d = ypc_pkg::ST_MUL_Y;
      ypc_pkg::ST_MUL_Y:      state_d = ypc_pkg::ST_UPDATE;
      ypc_pkg::ST_UPDATE:     state_d = ypc_pkg::ST_LOAD_YAW;
      ypc_pkg::ST_LOAD_YAW:   state_d = ypc_pkg::ST_RUN_YAW;
      ypc_pkg::ST_RUN_YAW:    if (cordic_res.done) state_d = ypc_pkg::ST_LOAD_PITCH;
      ypc_pkg::ST_LOAD_PITCH: state_d = ypc_pkg::ST_RUN_PITCH;
      ypc_pkg::ST_RUN_PITCH:  if (cordic_res.done) state_d = ypc_pkg::ST_PROD;
      ypc_pkg::ST_PROD:       if (pcnt_q == PcntLast) state_d = ypc_pkg::ST_EMIT;
      ypc_pkg::ST_EMIT:       if (can_load) state_d = ypc_pkg::ST_IDLE;
      default:                state_d = ypc_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready          = 1'b0;
    angle_upd         = 1'b0;
    cap_yaw           = 1'b0;
    load_out          = 1'b0;
    cordic_ctrl.start = 1'b0;
    cordic_ctrl.angle = $signed({1'b0, yaw});
    unique case (state_q)
      ypc_pkg::ST_IDLE:       in_ready = 1'b1;
      ypc_pkg::ST_UPDATE:     angle_upd = 1'b1;
      ypc_pkg::ST_LOAD_YAW:   cordic_ctrl.start = 1'b1;
      ypc_pkg::ST_RUN_YAW:    cap_yaw = cordic_res.done;
      ypc_pkg::ST_LOAD_PITCH: begin
        cordic_ctrl.start = 1'b1;
        cordic_ctrl.angle = ypc_pkg::ANGLE_W'(pitch);
      end
      ypc_pkg::ST_EMIT:       load_out = can_load;
      default: ;
    endcase
  end

  // Operands of the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ypc_pkg::ST_MUL_X: begin
        mul_a = ypc_pkg::MUL_W'(dx_q);
        mul_b = $signed({16'b0, sens_q});
      end
      ypc_pkg::ST_MUL_Y: begin
        mul_a = ypc_pkg::MUL_W'(dy_q);
        mul_b = $signed({16'b0, sens_q});
      end
      ypc_pkg::ST_PROD: begin
        unique case (pcnt_q)
          3'd0: begin
            mul_a = cy_q[ypc_pkg::MUL_W-1:0];
            mul_b = cordic_res.cos_v[ypc_pkg::MUL_W-1:0];
          end
          3'd1: begin
            mul_a = sy_q[ypc_pkg::MUL_W-1:0];
            mul_b = cordic_res.cos_v[ypc_pkg::MUL_W-1:0];
          end
          3'd2: begin
            mul_a = cy_q[ypc_pkg::MUL_W-1:0];
            mul_b = cordic_res.sin_v[ypc_pkg::MUL_W-1:0];
          end
          3'd3: begin
            mul_a = sy_q[ypc_pkg::MUL_W-1:0];
            mul_b = cordic_res.sin_v[ypc_pkg::MUL_W-1:0];
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign step_y = ypc_pkg::round_step(prod_q);

  // Up vector products are negated before rounding, as the cross product asks.
  assign emit_v = (pcnt_q == 3'd3 || pcnt_q == 3'd4) ?
                  ypc_pkg::emit_q(-prod_q, ypc_pkg::DROP_TWO) :
                  ypc_pkg::emit_q(prod_q, ypc_pkg::DROP_TWO);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ypc_pkg::ST_IDLE;
      sens_q      <= ypc_pkg::SENS_RESET;
      limit_q     <= ypc_pkg::LIMIT_RESET;
      out_valid_q <= 1'b0;
      pcnt_q      <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_index_i == ypc_pkg::CFG_SENSITIVITY) begin
          sens_q <= cfg_data_i[ypc_pkg::SENS_W-1:0];
        end else if (cfg_index_i == ypc_pkg::CFG_PITCH_LIMIT) begin
          limit_q <= cfg_data_i;
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ypc_pkg::ST_PROD) begin
        pcnt_q <= pcnt_q + 1'b1;
      end else begin
        pcnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (accept) begin
      dx_q <= mouse_dx_i;
      dy_q <= mouse_dy_i;
    end
    if (state_q == ypc_pkg::ST_MUL_Y) begin
      step_x_q <= ypc_pkg::round_step(prod_q);
    end
    if (cap_yaw) begin
      sy_q <= cordic_res.sin_v;
      cy_q <= cordic_res.cos_v;
    end
    if (state_q == ypc_pkg::ST_PROD) begin
      unique case (pcnt_q)
        3'd1:    fx_q <= emit_v;
        3'd2:    fz_q <= emit_v;
        3'd3:    ux_q <= emit_v;
        3'd4:    uz_q <= emit_v;
        default: ;
      endcase
    end
    if (load_out) begin
      forward_x_o <= fx_q;
      forward_z_o <= fz_q;
      upward_x_o  <= ux_q;
      upward_z_o  <= uz_q;
      forward_y_o <= ypc_pkg::emit_q(ypc_pkg::PROD_W'(cordic_res.sin_v), ypc_pkg::DROP_ONE);
      upward_y_o  <= ypc_pkg::emit_q(ypc_pkg::PROD_W'(cordic_res.cos_v), ypc_pkg::DROP_ONE);
      side_x_o    <= ypc_pkg::emit_q(-ypc_pkg::PROD_W'(sy_q), ypc_pkg::DROP_ONE);
      side_z_o    <= ypc_pkg::emit_q(ypc_pkg::PROD_W'(cy_q), ypc_pkg::DROP_ONE);
    end
  end

  ypc_angle u_angle (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .upd_i         (angle_upd),
    .step_x_i      (step_x_q),
    .step_y_i      (step_y),
    .pitch_limit_i (limit_q),
    .yaw_o         (yaw),
    .pitch_o       (pitch)
  );

  ypc_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (cordic_ctrl),
    .res_o  (cordic_res)
  );

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench of the yaw/pitch camera orientation block.
`timescale 1ns / 1ps

module tb_top;

  typedef logic [7:0][ypc_pkg::OUT_W-1:0] orient_word_t;

  localparam logic [ypc_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LO = 2'd2;
  localparam logic [ypc_pkg::CFG_IDX_W-1:0] CFG_UNUSED_HI = 2'd3;

  localparam longint FULL_TURN    = 64'sd23592960;
  localparam longint HALF_TURN    = 64'sd11796480;
  localparam longint QUARTER_TURN = 64'sd5898240;
  localparam longint GAIN_Q30     = 64'sd652032874;
  localparam int     NUM_STEPS    = (ypc_pkg::ROTATION_STEPS > 24) ? 24 :
                                    ypc_pkg::ROTATION_STEPS;
  localparam int     DROP_SINGLE  = 30 - ypc_pkg::VECTOR_FRAC_BITS;
  localparam int     DROP_PAIR    = 60 - ypc_pkg::VECTOR_FRAC_BITS;

  localparam longint ATAN_STEP [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  class orientation_board;
    longint          sens;
    longint          limit;
    longint          yaw;
    longint          pitch;
    int unsigned     mismatches;
    int unsigned     words_seen;
    orient_word_t    expected_q[$];
    string           field_name[8] = '{"forward_x", "forward_y", "forward_z", "side_x",
                                       "side_z", "upward_x", "upward_y", "upward_z"};

    function new();
      sens       = longint'(ypc_pkg::SENS_RESET);
      limit      = longint'(ypc_pkg::LIMIT_RESET);
      yaw        = 0;
      pitch      = 0;
      mismatches = 0;
      words_seen = 0;
    endfunction

    function void write_register(logic [ypc_pkg::CFG_IDX_W-1:0] idx,
                                 logic [ypc_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        ypc_pkg::CFG_SENSITIVITY: sens = longint'(data[ypc_pkg::SENS_W-1:0]);
        ypc_pkg::CFG_PITCH_LIMIT: limit = longint'(data[ypc_pkg::LIMIT_W-1:0]);
        default: ;
      endcase
    endfunction

    // Rotation-mode CORDIC, folded into the right half plane first.
    function void sin_cos(input longint ang, output longint s, output longint c);
      longint a;
      longint x;
      longint y;
      longint nx;
      bit     flip;
      a    = ang % FULL_TURN;
      x    = GAIN_Q30;
      y    = 0;
      flip = 1'b0;
      if (a > HALF_TURN) a -= FULL_TURN;
      if (a <= -HALF_TURN) a += FULL_TURN;
      if (a > QUARTER_TURN) begin
        a -= HALF_TURN;
        flip = 1'b1;
      end else if (a < -QUARTER_TURN) begin
        a += HALF_TURN;
        flip = 1'b1;
      end
      for (int i = 0; i < NUM_STEPS; i++) begin
        if (a >= 0) begin
          nx = x - (y >>> i);
          y  = y + (x >>> i);
          a -= ATAN_STEP[i];
        end else begin
          nx = x + (y >>> i);
          y  = y - (x >>> i);
          a += ATAN_STEP[i];
        end
        x = nx;
      end
      if (flip) begin
        x = -x;
        y = -y;
      end
      s = y;
      c = x;
    endfunction

    function logic [ypc_pkg::OUT_W-1:0] to_q(longint v, int drop);
      longint one;
      longint r;
      one = longint'(1) <<< ypc_pkg::VECTOR_FRAC_BITS;
      r   = v;
      if (drop > 0) r = (v + (longint'(1) <<< (drop - 1))) >>> drop;
      if (r > one) r = one;
      if (r < -one) r = -one;
      return r[ypc_pkg::OUT_W-1:0];
    endfunction

    function void note_delta(logic signed [ypc_pkg::DELTA_W-1:0] dx,
                             logic signed [ypc_pkg::DELTA_W-1:0] dy);
      longint       yaw_step;
      longint       pitch_step;
      longint       lim;
      longint       sy;
      longint       cy;
      longint       sp;
      longint       cp;
      orient_word_t w;
      yaw_step   = (longint'(dx) * sens + 128) >>> 8;
      pitch_step = (longint'(dy) * sens + 128) >>> 8;
      yaw = ((yaw + yaw_step) % FULL_TURN + FULL_TURN) % FULL_TURN;
      lim = (limit > QUARTER_TURN) ? QUARTER_TURN : limit;
      pitch += pitch_step;
      if (pitch > lim) pitch = lim;
      if (pitch < -lim) pitch = -lim;
      sin_cos(yaw, sy, cy);
      sin_cos(pitch, sp, cp);
      w[0] = to_q(cy * cp, DROP_PAIR);
      w[1] = to_q(sp, DROP_SINGLE);
      w[2] = to_q(sy * cp, DROP_PAIR);
      w[3] = to_q(-sy, DROP_SINGLE);
      w[4] = to_q(cy, DROP_SINGLE);
      w[5] = to_q(-(cy * sp), DROP_PAIR);
      w[6] = to_q(cp, DROP_SINGLE);
      w[7] = to_q(-(sy * sp), DROP_PAIR);
      expected_q.push_back(w);
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      mismatches++;
    endtask

    task check_word(orient_word_t got);
      orient_word_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("output word %0d arrived with nothing expected", words_seen));
      end else begin
        want = expected_q.pop_front();
        for (int i = 0; i < 8; i++) begin
          if (got[i] !== want[i]) begin
            report($sformatf("word %0d %s got %0d expected %0d", words_seen, field_name[i],
                             $signed(got[i]), $signed(want[i])));
          end
        end
      end
      words_seen++;
    endtask
  endclass

  logic                                   clk_i       = 1'b0;
  logic                                   rst_ni      = 1'b0;
  logic                                   cfg_we_i    = 1'b0;
  logic [ypc_pkg::CFG_IDX_W-1:0]          cfg_index_i = '0;
  logic [ypc_pkg::CFG_DATA_W-1:0]         cfg_data_i  = '0;
  logic                                   in_valid_i  = 1'b0;
  logic                                   in_ready_o;
  logic signed [ypc_pkg::DELTA_W-1:0]     mouse_dx_i  = '0;
  logic signed [ypc_pkg::DELTA_W-1:0]     mouse_dy_i  = '0;
  logic                                   out_valid_o;
  logic                                   out_ready_i = 1'b0;
  logic signed [ypc_pkg::OUT_W-1:0]       forward_x_o;
  logic signed [ypc_pkg::OUT_W-1:0]       forward_y_o;
  logic signed [ypc_pkg::OUT_W-1:0]       forward_z_o;
  logic signed [ypc_pkg::OUT_W-1:0]       side_x_o;
  logic signed [ypc_pkg::OUT_W-1:0]       side_z_o;
  logic signed [ypc_pkg::OUT_W-1:0]       upward_x_o;
  logic signed [ypc_pkg::OUT_W-1:0]       upward_y_o;
  logic signed [ypc_pkg::OUT_W-1:0]       upward_z_o;

  orientation_board board;
  bit               no_idle      = 1'b0;
  bit               hold_request = 1'b0;

  yaw_pitch_camera_orientation u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mouse_dx_i  (mouse_dx_i),
    .mouse_dy_i  (mouse_dy_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .forward_x_o (forward_x_o),
    .forward_y_o (forward_y_o),
    .forward_z_o (forward_z_o),
    .side_x_o    (side_x_o),
    .side_z_o    (side_z_o),
    .upward_x_o  (upward_x_o),
    .upward_y_o  (upward_y_o),
    .upward_z_o  (upward_z_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: random back-pressure, or a long hold-off when the sender asks for one.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        out_ready_i = 1'b0;
        repeat (400) @(negedge clk_i);
        hold_request = 1'b0;
      end else begin
        out_ready_i = no_idle || ($urandom_range(99) >= 35);
      end
    end
  end

  always @(posedge clk_i) begin : take_word
    orient_word_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {upward_z_o, upward_y_o, upward_x_o, side_z_o, side_x_o,
             forward_z_o, forward_y_o, forward_x_o};
      board.check_word(got);
    end
  end

  task automatic write_reg(input logic [ypc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ypc_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    board.write_register(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Offer one delta and hold it until the block takes the word.
  task automatic offer_delta(input logic [ypc_pkg::DELTA_W-1:0] dx,
                             input logic [ypc_pkg::DELTA_W-1:0] dy);
    in_valid_i = 1'b1;
    mouse_dx_i = dx;
    mouse_dy_i = dy;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_delta(dx, dy);
    @(negedge clk_i);
  endtask

  task automatic sender_gap();
    if (!no_idle && $urandom_range(99) < 35) begin
      in_valid_i = 1'b0;
      mouse_dx_i = ypc_pkg::DELTA_W'($urandom);
      mouse_dy_i = ypc_pkg::DELTA_W'($urandom);
      repeat ($urandom_range(60, 1)) @(negedge clk_i);
    end
  endtask

  // Wait until every expected word has been taken, then let the sequencer settle.
  task automatic drain();
    in_valid_i = 1'b0;
    while (board.expected_q.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  function automatic logic [ypc_pkg::DELTA_W-1:0] pick_delta();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 5) return ypc_pkg::DELTA_W'($urandom);
    if (r < 8) return ypc_pkg::DELTA_W'(int'($urandom_range(1023)) - 512);
    if (r == 8) return $urandom_range(1) ? 16'h7FFF : 16'h8000;
    return ypc_pkg::DELTA_W'($urandom_range(511) * 128);
  endfunction

  function automatic logic [ypc_pkg::CFG_DATA_W-1:0] pick_sens();
    logic [ypc_pkg::CFG_DATA_W-1:0] d;
    d = ypc_pkg::CFG_DATA_W'($urandom);
    case ($urandom_range(4))
      0: d[ypc_pkg::SENS_W-1:0] = '0;
      1: d[ypc_pkg::SENS_W-1:0] = '1;
      2: d[ypc_pkg::SENS_W-1:0] = ypc_pkg::SENS_RESET;
      default: ;
    endcase
    return d;
  endfunction

  function automatic logic [ypc_pkg::CFG_DATA_W-1:0] pick_limit();
    case ($urandom_range(6))
      0: return '0;
      1: return ypc_pkg::LIMIT_RESET;
      2: return 23'd5898240;
      3: return '1;
      4: return ypc_pkg::CFG_DATA_W'($urandom_range(65536, 1));
      default: return ypc_pkg::CFG_DATA_W'($urandom);
    endcase
  endfunction

  initial begin
    board = new();
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Default settings: extremes and rounding ties.
    offer_delta(16'h0000, 16'h0000);
    offer_delta(16'h7FFF, 16'h7FFF);
    offer_delta(16'h8000, 16'h8000);
    offer_delta(16'd128, -16'sd128);
    offer_delta(16'hFFFF, 16'h0001);
    offer_delta(16'h7FFF, 16'h8000);

    // Full sensitivity, pitch limit beyond a quarter turn: pitch pins at 90 degrees.
    drain();
    write_reg(ypc_pkg::CFG_SENSITIVITY, '1);
    write_reg(ypc_pkg::CFG_PITCH_LIMIT, '1);
    offer_delta(16'h0000, 16'h7FFF);
    offer_delta(16'h7FFF, 16'h7FFF);
    offer_delta(16'h8000, 16'h8000);
    offer_delta(16'h8000, 16'h8000);

    // Steps of exactly 90 degrees land on the quadrant boundaries.
    drain();
    write_reg(ypc_pkg::CFG_SENSITIVITY, 23'd49152);
    write_reg(ypc_pkg::CFG_PITCH_LIMIT, 23'd5898240);
    write_reg(CFG_UNUSED_LO, ypc_pkg::CFG_DATA_W'($urandom));
    write_reg(CFG_UNUSED_HI, ypc_pkg::CFG_DATA_W'($urandom));
    offer_delta(16'd30720, 16'd30720);
    offer_delta(16'd30720, 16'd30720);
    offer_delta(16'd30720, -16'sd30720);
    offer_delta(16'd30720, -16'sd30720);

    // A limit lowered below the stored pitch takes hold at the next word.
    drain();
    write_reg(ypc_pkg::CFG_PITCH_LIMIT, '0);
    offer_delta(16'h0000, 16'h0000);
    offer_delta(16'd12345, 16'h8000);

    drain();
    write_reg(ypc_pkg::CFG_SENSITIVITY, '0);
    offer_delta(16'h7FFF, 16'h8000);
    offer_delta(16'h8000, 16'h7FFF);

    // Unit sensitivity shows the rounding of the step directly.
    drain();
    write_reg(ypc_pkg::CFG_SENSITIVITY, 23'd1);
    write_reg(ypc_pkg::CFG_PITCH_LIMIT, 23'd65536);
    offer_delta(16'h7FFF, 16'h7FFF);
    offer_delta(16'h8000, 16'h8000);
    offer_delta(16'd127, -16'sd129);
    offer_delta(16'd128, -16'sd128);

    for (int phase = 0; phase < 8; phase++) begin
      drain();
      no_idle = (phase == 3);
      if (phase == 0) begin
        write_reg(ypc_pkg::CFG_SENSITIVITY, '1);
        write_reg(ypc_pkg::CFG_PITCH_LIMIT, '1);
      end else if (phase == 1) begin
        write_reg(ypc_pkg::CFG_SENSITIVITY, ypc_pkg::CFG_DATA_W'(ypc_pkg::SENS_RESET));
        write_reg(ypc_pkg::CFG_PITCH_LIMIT, ypc_pkg::LIMIT_RESET);
      end else begin
        write_reg(ypc_pkg::CFG_SENSITIVITY, pick_sens());
        write_reg(ypc_pkg::CFG_PITCH_LIMIT, pick_limit());
      end
      write_reg($urandom_range(1) ? CFG_UNUSED_LO : CFG_UNUSED_HI,
                ypc_pkg::CFG_DATA_W'($urandom));
      for (int k = 0; k < 105; k++) begin
        if (phase == 1 && k == 40) hold_request = 1'b1;
        if (phase == 5 && k == 50) begin
          in_valid_i = 1'b0;
          while (board.expected_q.size() != 0) @(negedge clk_i);
        end
        offer_delta(pick_delta(), pick_delta());
        sender_gap();
      end
    end
    no_idle = 1'b0;

    drain();
    if (board.expected_q.size() != 0) begin
      board.report($sformatf("%0d expected words never arrived", board.expected_q.size()));
    end
    if (board.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/ypc_pkg.sv
hdl/ypc_angle.sv
hdl/ypc_cordic.sv
hdl/yaw_pitch_camera_orientation.sv
tb/tb_top.sv
